// ===== src/mcit_pkg.sv =====
// ----------------------------------------------------------------------------
// mcit_pkg
// Shared constants and types for the multi-column interpolation table.
// ----------------------------------------------------------------------------
package mcit_pkg;

  // Default values for the top-level parameters.
  localparam int TABLE_ROWS_DEF = 16384;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths.
  localparam int ROW_W    = 14;   // row index and last_row register
  localparam int GRID_W   = 22;   // Q14.8 grid position
  localparam int QPOS_W   = 24;   // Q15.8 signed query position
  localparam int MAG_W    = 24;   // magnitude, up to 2^23
  localparam int SCALE_W  = 16;   // Q8.8 bin scale
  localparam int CFG_W    = 16;   // configuration write data
  localparam int CFG_IDX_W = 1;
  localparam int D_W      = 15;   // clamped weight, -8192 .. 8192
  localparam int D_LIMIT  = 8192;
  localparam int NUM_COLS = 5;    // rho, alpha, tau, time0, ampli

  // Column slots inside a packed table row.
  localparam int COL_RHO   = 0;
  localparam int COL_ALPHA = 1;
  localparam int COL_TAU   = 2;
  localparam int COL_TIME0 = 3;
  localparam int COL_AMPLI = 4;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_LAST_ROW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE = 1'b1;
  localparam logic [ROW_W-1:0]   LAST_ROW_RST  = 14'd1;
  localparam logic [SCALE_W-1:0] BIN_SCALE_RST = 16'd6400;

  // A query travelling alongside the table read.
  typedef struct packed {
    logic             valid;
    logic [MAG_W-1:0] mag;
  } query_tag_t;

endpackage

// ===== src/mcit_ram.sv =====
// ----------------------------------------------------------------------------
// mcit_ram
// Generic RAM: one write port and a set of registered read ports.
// ----------------------------------------------------------------------------
module mcit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int READS = 1,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr [READS],
  output logic [WIDTH-1:0] rdata [READS]
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  for (genvar k = 0; k < READS; k++) begin : g_rd
    always_ff @(posedge clk) begin
      rdata[k] <= mem[raddr[k]];
    end
  end

endmodule

// ===== src/mcit_table.sv =====
// ----------------------------------------------------------------------------
// mcit_table
// Input register, row address calculation and the table storage.
// ----------------------------------------------------------------------------
module mcit_table #(
  parameter int TABLE_ROWS = 16384,
  parameter int VALUE_BITS = 32,
  localparam int ROW_DW    = mcit_pkg::GRID_W + mcit_pkg::NUM_COLS * VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic                                kind,
  input  logic [mcit_pkg::ROW_W-1:0]          row_index,
  input  logic [ROW_DW-1:0]                   row_in,
  input  logic [mcit_pkg::QPOS_W-1:0]         query_pos,
  input  logic [mcit_pkg::ROW_W-1:0]          last_row,
  output mcit_pkg::query_tag_t                qtag,
  output logic [ROW_DW-1:0]                   row_lo,
  output logic [ROW_DW-1:0]                   row_hi,
  output logic [ROW_DW-1:0]                   row_lr
);
  import mcit_pkg::*;

  localparam int IDX_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam logic [16:0] ROWS_EXT = 17'(TABLE_ROWS);
  localparam logic [16:0] LAST_IDX = 17'(TABLE_ROWS - 1);

  logic [MAG_W-1:0]  mag_in;
  logic [16:0]       lo_raw;
  logic [16:0]       lr_raw;
  logic [IDX_W-1:0]  lo_in;
  logic [IDX_W-1:0]  hi_in;
  logic [IDX_W-1:0]  lr_in;
  logic              row_ok;

  // Stage 0 registers.
  logic              v0;
  logic              kind0;
  logic              wok0;
  logic [MAG_W-1:0]  mag0;
  logic [IDX_W-1:0]  lo0;
  logic [IDX_W-1:0]  hi0;
  logic [IDX_W-1:0]  lr0;
  logic [IDX_W-1:0]  waddr0;
  logic [ROW_DW-1:0] wdata0;
  logic              we0;

  logic [IDX_W-1:0]  raddr_a [2];
  logic [ROW_DW-1:0] rdata_a [2];
  logic [IDX_W-1:0]  raddr_b [1];
  logic [ROW_DW-1:0] rdata_b [1];

  always_comb begin
    mag_in = query_pos[QPOS_W-1] ? (~query_pos + 1'b1) : query_pos;
    lo_raw = {1'b0, mag_in[MAG_W-1:8]};
    lo_in  = (lo_raw > LAST_IDX) ? LAST_IDX[IDX_W-1:0] : lo_raw[IDX_W-1:0];
    hi_in  = ({{(17-IDX_W){1'b0}}, lo_in} == LAST_IDX) ? lo_in : lo_in + 1'b1;
    lr_raw = {3'b000, last_row};
    lr_in  = (lr_raw > LAST_IDX) ? LAST_IDX[IDX_W-1:0] : lr_raw[IDX_W-1:0];
    row_ok = ({3'b000, row_index} < ROWS_EXT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= take;
    end
    kind0  <= kind;
    wok0   <= row_ok;
    mag0   <= mag_in;
    lo0    <= lo_in;
    hi0    <= hi_in;
    lr0    <= lr_in;
    waddr0 <= IDX_W'({3'b000, row_index});
    wdata0 <= row_in;
  end

  assign we0 = v0 && (kind0 == KIND_LOAD) && wok0;

  assign raddr_a[0] = lo0;
  assign raddr_a[1] = hi0;
  assign raddr_b[0] = lr0;

  // Two copies of the table: one serves the interpolation pair, the other
  // the last row that holds the limit and the default values.
  mcit_ram #(.WIDTH(ROW_DW), .DEPTH(TABLE_ROWS), .READS(2)) u_pair_ram (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mcit_ram #(.WIDTH(ROW_DW), .DEPTH(TABLE_ROWS), .READS(1)) u_last_ram (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      qtag.valid <= 1'b0;
    end else begin
      qtag.valid <= v0 && (kind0 == KIND_QUERY);
    end
    qtag.mag <= mag0;
  end

  assign row_lo = rdata_a[0];
  assign row_hi = rdata_a[1];
  assign row_lr = rdata_b[0];

endmodule

// ===== src/mcit_lerp.sv =====
// ----------------------------------------------------------------------------
// mcit_lerp
// Three-stage linear interpolation of one column with round and saturate.
// ----------------------------------------------------------------------------
module mcit_lerp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic signed [VALUE_BITS-1:0]       ylo,
  input  logic signed [VALUE_BITS-1:0]       yhi,
  input  logic signed [VALUE_BITS-1:0]       ylr,
  input  logic                               beyond,
  input  logic signed [mcit_pkg::D_W-1:0]    d,
  output logic signed [VALUE_BITS-1:0]       y
);
  import mcit_pkg::*;

  localparam int DIFF_W = VALUE_BITS + 1;
  localparam int PROD_W = VALUE_BITS + 16;
  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO =
    {{(PROD_W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(128);

  logic signed [VALUE_BITS-1:0] base_a;
  logic signed [DIFF_W-1:0]     diff_a;
  logic signed [D_W-1:0]        d_a;
  logic signed [VALUE_BITS-1:0] base_b;
  logic signed [PROD_W-1:0]     prod_b;
  logic signed [PROD_W-1:0]     rnd;
  logic signed [PROD_W-1:0]     sum;

  // Stage A: pick the base and form the slope.
  always_ff @(posedge clk) begin
    base_a <= beyond ? ylr : ylo;
    diff_a <= DIFF_W'(yhi) - DIFF_W'(ylo);
    d_a    <= d;
  end

  // Stage B: weight times slope.
  always_ff @(posedge clk) begin
    base_b <= base_a;
    prod_b <= PROD_W'(d_a) * PROD_W'(diff_a);
  end

  // Stage C: round half up, add the base, clamp.
  always_comb begin
    rnd = (prod_b + HALF) >>> 8;
    sum = PROD_W'(base_b) + rnd;
  end

  always_ff @(posedge clk) begin
    if (sum > SAT_HI) begin
      y <= SAT_HI[VALUE_BITS-1:0];
    end else if (sum < SAT_LO) begin
      y <= SAT_LO[VALUE_BITS-1:0];
    end else begin
      y <= sum[VALUE_BITS-1:0];
    end
  end

endmodule

// ===== src/mcit_scale.sv =====
// ----------------------------------------------------------------------------
// mcit_scale
// Two-stage multiply of tau by the Q8.8 bin scale with round and saturate.
// ----------------------------------------------------------------------------
module mcit_scale #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic signed [VALUE_BITS-1:0]        tau,
  input  logic [mcit_pkg::SCALE_W-1:0]        bin_scale,
  output logic signed [VALUE_BITS-1:0]        tau_bins
);
  import mcit_pkg::*;

  localparam int PROD_W = VALUE_BITS + SCALE_W + 1;
  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO =
    {{(PROD_W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(128);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(tau) * $signed({{(PROD_W-SCALE_W){1'b0}}, bin_scale});
  end

  assign rnd = (prod + HALF) >>> 8;

  always_ff @(posedge clk) begin
    if (rnd > SAT_HI) begin
      tau_bins <= SAT_HI[VALUE_BITS-1:0];
    end else if (rnd < SAT_LO) begin
      tau_bins <= SAT_LO[VALUE_BITS-1:0];
    end else begin
      tau_bins <= rnd[VALUE_BITS-1:0];
    end
  end

endmodule

// ===== src/multi_column_interp_table.sv =====
// ----------------------------------------------------------------------------
// multi_column_interp_table
// Piecewise linear interpolation of five signal-shape columns over a
// unit-spaced position table, with a scaled tau output.
// ----------------------------------------------------------------------------
//
// Channel      Signals                                   Transaction
// -----------  ----------------------------------------  ---------------------
// command      start, busy, kind, row_index, grid_x,     start && !busy
//              load_*, query_pos
// result       done, rho_out .. ampli_out, tau_bins_out, done (one cycle)
//              beyond_table
// config       cfg_we, cfg_index, cfg_data               cfg_we
//
// A new transaction can be taken in every cycle while busy is low. A query
// puts its result on the result ports, marked by done; a load writes its row
// from the input register into both table copies and gives no result. A
// result passes through the input register, the registered table read, three
// interpolation stages and the two stages of the bin-scale multiplier. The
// receiver cannot stall, so the pipeline never holds; busy is high only while
// rst is high.
// Reset is synchronous and clears the valid bits and the configuration
// registers; the table itself is not cleared and is undefined until loaded.
//
// The table is kept in two identical RAM copies that are written together:
// one copy reads the row pair around the query, the other reads the last
// row, whose grid position is the upper limit and whose values are the
// defaults. At or beyond that limit the weight is forced to zero and the
// last row is used as the base, so the same arithmetic returns the default.
// ----------------------------------------------------------------------------
module multi_column_interp_table #(
  parameter int TABLE_ROWS = mcit_pkg::TABLE_ROWS_DEF,
  parameter int VALUE_BITS = mcit_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 kind,
  input  logic [mcit_pkg::ROW_W-1:0]           row_index,
  input  logic [mcit_pkg::GRID_W-1:0]          grid_x,
  input  logic signed [VALUE_BITS-1:0]         load_rho,
  input  logic signed [VALUE_BITS-1:0]         load_alpha,
  input  logic signed [VALUE_BITS-1:0]         load_tau,
  input  logic signed [VALUE_BITS-1:0]         load_time0,
  input  logic signed [VALUE_BITS-1:0]         load_ampli,
  input  logic signed [mcit_pkg::QPOS_W-1:0]   query_pos,
  // result
  output logic                                 done,
  output logic signed [VALUE_BITS-1:0]         rho_out,
  output logic signed [VALUE_BITS-1:0]         alpha_out,
  output logic signed [VALUE_BITS-1:0]         tau_out,
  output logic signed [VALUE_BITS-1:0]         tau_bins_out,
  output logic signed [VALUE_BITS-1:0]         time0_out,
  output logic signed [VALUE_BITS-1:0]         ampli_out,
  output logic                                 beyond_table,
  // configuration
  input  logic                                 cfg_we,
  input  logic [mcit_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcit_pkg::CFG_W-1:0]           cfg_data
);
  import mcit_pkg::*;

  localparam int ROW_DW  = GRID_W + NUM_COLS * VALUE_BITS;
  localparam int DFULL_W = MAG_W + 1;
  localparam logic signed [DFULL_W-1:0] D_HI = DFULL_W'(D_LIMIT);
  localparam logic signed [DFULL_W-1:0] D_LO = -D_HI;

  // Configuration registers.
  logic [ROW_W-1:0]   last_row;
  logic [SCALE_W-1:0] bin_scale;

  logic               take;
  logic [ROW_DW-1:0]  row_in;
  query_tag_t         qtag;
  logic [ROW_DW-1:0]  row_lo;
  logic [ROW_DW-1:0]  row_hi;
  logic [ROW_DW-1:0]  row_lr;

  // Stage 1 decisions on the table read.
  logic [GRID_W-1:0]         grid_lo;
  logic [GRID_W-1:0]         grid_lr;
  logic                      beyond1;
  logic signed [DFULL_W-1:0] d_full;
  logic signed [D_W-1:0]     d1;

  // Pipeline valid and flag bits.
  logic v2, v3, v4, v5;
  logic beyond2, beyond3, beyond4, beyond5;

  logic signed [VALUE_BITS-1:0] col4 [NUM_COLS];
  logic signed [VALUE_BITS-1:0] col5 [NUM_COLS];
  logic signed [VALUE_BITS-1:0] tau_bins6;

  assign busy = rst;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_row  <= LAST_ROW_RST;
      bin_scale <= BIN_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAST_ROW:  last_row  <= cfg_data[ROW_W-1:0];
        REG_BIN_SCALE: bin_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Row layout: grid position on top, then rho down to ampli.
  assign row_in = {grid_x, load_rho, load_alpha, load_tau, load_time0, load_ampli};

  mcit_table #(.TABLE_ROWS(TABLE_ROWS), .VALUE_BITS(VALUE_BITS)) u_table (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .kind      (kind),
    .row_index (row_index),
    .row_in    (row_in),
    .query_pos (query_pos),
    .last_row  (last_row),
    .qtag      (qtag),
    .row_lo    (row_lo),
    .row_hi    (row_hi),
    .row_lr    (row_lr)
  );

  // The limit test and the clamped weight. The weight is clamped to plus or
  // minus 32 grid units so that an uneven grid cannot blow up the product.
  always_comb begin
    grid_lo = row_lo[NUM_COLS*VALUE_BITS +: GRID_W];
    grid_lr = row_lr[NUM_COLS*VALUE_BITS +: GRID_W];
    beyond1 = (qtag.mag >= {{(MAG_W-GRID_W){1'b0}}, grid_lr});
    d_full  = $signed({1'b0, qtag.mag}) - $signed({{(DFULL_W-GRID_W){1'b0}}, grid_lo});
    if (beyond1) begin
      d1 = '0;
    end else if (d_full > D_HI) begin
      d1 = D_HI[D_W-1:0];
    end else if (d_full < D_LO) begin
      d1 = D_LO[D_W-1:0];
    end else begin
      d1 = d_full[D_W-1:0];
    end
  end

  // Slot c sits at bit offset (NUM_COLS-1-c)*VALUE_BITS in a row.
  for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
    mcit_lerp #(.VALUE_BITS(VALUE_BITS)) u_lerp (
      .clk    (clk),
      .ylo    (row_lo[(NUM_COLS-1-c)*VALUE_BITS +: VALUE_BITS]),
      .yhi    (row_hi[(NUM_COLS-1-c)*VALUE_BITS +: VALUE_BITS]),
      .ylr    (row_lr[(NUM_COLS-1-c)*VALUE_BITS +: VALUE_BITS]),
      .beyond (beyond1),
      .d      (d1),
      .y      (col4[c])
    );
  end

  mcit_scale #(.VALUE_BITS(VALUE_BITS)) u_scale (
    .clk       (clk),
    .tau       (col4[COL_TAU]),
    .bin_scale (bin_scale),
    .tau_bins  (tau_bins6)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v2   <= qtag.valid;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
    beyond2 <= beyond1;
    beyond3 <= beyond2;
    beyond4 <= beyond3;
    beyond5 <= beyond4;
    col5    <= col4;
  end

  // Result register, aligned with the bin-scale multiplier output.
  always_ff @(posedge clk) begin
    rho_out      <= col5[COL_RHO];
    alpha_out    <= col5[COL_ALPHA];
    tau_out      <= col5[COL_TAU];
    time0_out    <= col5[COL_TIME0];
    ampli_out    <= col5[COL_AMPLI];
    beyond_table <= beyond5;
  end

  assign tau_bins_out = tau_bins6;

  // Every accepted query gives exactly one result.
  a_query_done: assert property (@(posedge clk) disable iff (rst)
    (take && kind == KIND_QUERY) |-> ##7 done)
    else $error("query transaction did not produce a result");

  // A load never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (take && kind == KIND_LOAD) |-> ##7 !done)
    else $error("load transaction produced a result");

  // Nothing leaves the pipeline that did not enter it as a query.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v5))
    else $error("result strobe without a query in flight");

endmodule

// ===== dv/multi_column_interp_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_column_interp_table_tb
// Self-checking bench for the multi-column interpolation table. Table rows
// and queries go through the command port, and the register port sets up the
// last row and the bin scale between phases. An in-bench table model predicts
// every query result, and each result is checked against it field by field.
// ----------------------------------------------------------------------------
module multi_column_interp_table_tb;
  import mcit_pkg::*;

  localparam int VB           = VALUE_BITS_DEF;
  localparam int TR           = TABLE_ROWS_DEF;
  // Rows 0 .. WIN_ROWS-1 form the unit-spaced working window that most
  // queries land in. They are reloaded at the start of each random phase.
  localparam int WIN_ROWS     = 50;
  // This margin covers a query result still on its way through the pipeline,
  // and also a load that is still being written when the port goes quiet.
  localparam int DRAIN_CYCLES = 12;
  // Cycles with no transaction at all before the run is declared hung.
  localparam int QUIET_LIMIT  = 2000;

  // One command transaction, as the bench queues and drives it.
  typedef struct packed {
    logic                     kind;
    logic [ROW_W-1:0]         row;
    logic [GRID_W-1:0]        grid;
    logic signed [VB-1:0]     rho, alpha, tau, time0, ampli;
    logic signed [QPOS_W-1:0] pos;
  } command_t;

  // One interpolated signal shape, as it comes out of the result port.
  typedef struct packed {
    logic signed [VB-1:0] rho, alpha, tau, tau_bins, time0, ampli;
    logic                 beyond;
  } shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     start      = 1'b0;
  logic                     busy;
  logic                     kind       = KIND_LOAD;
  logic [ROW_W-1:0]         row_index  = '0;
  logic [GRID_W-1:0]        grid_x     = '0;
  logic signed [VB-1:0]     load_rho   = '0;
  logic signed [VB-1:0]     load_alpha = '0;
  logic signed [VB-1:0]     load_tau   = '0;
  logic signed [VB-1:0]     load_time0 = '0;
  logic signed [VB-1:0]     load_ampli = '0;
  logic signed [QPOS_W-1:0] query_pos  = '0;
  logic                     done;
  logic signed [VB-1:0]     rho_out, alpha_out, tau_out, tau_bins_out;
  logic signed [VB-1:0]     time0_out, ampli_out;
  logic                     beyond_table;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index  = REG_LAST_ROW;
  logic [CFG_W-1:0]         cfg_data   = '0;

  multi_column_interp_table #(
    .TABLE_ROWS (TR),
    .VALUE_BITS (VB)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .row_index    (row_index),
    .grid_x       (grid_x),
    .load_rho     (load_rho),
    .load_alpha   (load_alpha),
    .load_tau     (load_tau),
    .load_time0   (load_time0),
    .load_ampli   (load_ampli),
    .query_pos    (query_pos),
    .done         (done),
    .rho_out      (rho_out),
    .alpha_out    (alpha_out),
    .tau_out      (tau_out),
    .tau_bins_out (tau_bins_out),
    .time0_out    (time0_out),
    .ampli_out    (ampli_out),
    .beyond_table (beyond_table),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench-side copy of the block state. The table copy is updated when a load
  // is accepted, so queries see exactly the rows loaded before them. The
  // register copy changes only while the block is idle.
  // --------------------------------------------------------------------------
  logic [GRID_W-1:0]    grid_col  [TR];
  logic signed [VB-1:0] shape_col [NUM_COLS][TR];
  logic [ROW_W-1:0]     cfg_last_row  = LAST_ROW_RST;
  logic [SCALE_W-1:0]   cfg_bin_scale = BIN_SCALE_RST;

  // What the stimulus has queued so far. A row is only read by a query after
  // it has been loaded, so the bench never touches an undefined table entry.
  bit                row_loaded   [TR];
  logic [GRID_W-1:0] planned_grid [TR];

  command_t command_q [$];
  shape_t   expected_shapes [$];
  command_t current_cmd = '0;
  bit       holding = 1'b0;   // current_cmd is on the port, not yet taken
  int       sender_idle_pct = 37;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  function automatic longint magnitude(input logic signed [QPOS_W-1:0] p);
    longint q;
    q = p;
    return (q < 0) ? -q : q;
  endfunction

  // Rows bracketing a magnitude; both saturate at the top of the table.
  function automatic void row_pair(input longint mag, output int lo, output int hi);
    lo = ((mag >> 8) > TR - 1) ? TR - 1 : int'(mag >> 8);
    hi = (lo + 1 > TR - 1) ? TR - 1 : lo + 1;
  endfunction

  function automatic longint clamp_value(input longint v);
    longint top;
    top = (longint'(1) <<< (VB - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  // Applies one accepted transaction to the table copy. A load updates a row;
  // a query interpolates all five columns and queues the expected shape.
  function automatic void apply_command(input command_t c);
    longint mag, d, base, tau_b;
    longint y [NUM_COLS];
    int     lo, hi, k;
    shape_t s;
    if (c.kind == KIND_LOAD) begin
      grid_col[c.row]             = c.grid;
      shape_col[COL_RHO][c.row]   = c.rho;
      shape_col[COL_ALPHA][c.row] = c.alpha;
      shape_col[COL_TAU][c.row]   = c.tau;
      shape_col[COL_TIME0][c.row] = c.time0;
      shape_col[COL_AMPLI][c.row] = c.ampli;
      return;
    end
    mag = magnitude(c.pos);
    s.beyond = (mag >= longint'(grid_col[cfg_last_row]));
    if (s.beyond) begin
      for (k = 0; k < NUM_COLS; k++) y[k] = shape_col[k][cfg_last_row];
    end else begin
      row_pair(mag, lo, hi);
      d = mag - longint'(grid_col[lo]);
      // A badly spaced grid would otherwise extrapolate without bound.
      if (d > D_LIMIT) d = D_LIMIT;
      else if (d < -D_LIMIT) d = -D_LIMIT;
      for (k = 0; k < NUM_COLS; k++) begin
        base = shape_col[k][lo];
        y[k] = clamp_value(base + ((d * (longint'(shape_col[k][hi]) - base) + 128) >>> 8));
      end
    end
    tau_b = clamp_value((y[COL_TAU] * longint'(cfg_bin_scale) + 128) >>> 8);
    s.rho      = y[COL_RHO][VB-1:0];
    s.alpha    = y[COL_ALPHA][VB-1:0];
    s.tau      = y[COL_TAU][VB-1:0];
    s.tau_bins = tau_b[VB-1:0];
    s.time0    = y[COL_TIME0][VB-1:0];
    s.ampli    = y[COL_AMPLI][VB-1:0];
    expected_shapes = {expected_shapes, s};
  endfunction

  // True when every row this query may read has been loaded already.
  function automatic bit rows_ready(input logic signed [QPOS_W-1:0] p);
    int lo, hi;
    row_pair(magnitude(p), lo, hi);
    return row_loaded[lo] && row_loaded[hi] && row_loaded[cfg_last_row];
  endfunction

  // Half full-range values, half small ones closer to real shape data.
  function automatic logic signed [VB-1:0] random_value();
    if ($urandom_range(1)) return $urandom;
    return int'($urandom_range(2097152)) - 1048576;
  endfunction

  // A position inside the working window, with a random sign.
  function automatic logic signed [QPOS_W-1:0] window_pos();
    longint mag;
    mag = $urandom_range((WIN_ROWS - 1) * 256 - 1);
    return $urandom_range(1) ? QPOS_W'(-mag) : QPOS_W'(mag);
  endfunction

  task automatic queue_load(input int row, input logic [GRID_W-1:0] grid,
                            input logic signed [VB-1:0] rho, alpha, tau, time0, ampli);
    command_t c;
    c.kind  = KIND_LOAD;
    c.row   = ROW_W'(row);
    c.grid  = grid;
    c.rho   = rho;
    c.alpha = alpha;
    c.tau   = tau;
    c.time0 = time0;
    c.ampli = ampli;
    c.pos   = QPOS_W'($urandom);   // ignored by a load
    command_q = {command_q, c};
    row_loaded[row]   = 1'b1;
    planned_grid[row] = grid;
  endtask

  task automatic queue_random_load(input int row, input logic [GRID_W-1:0] grid);
    queue_load(row, grid, random_value(), random_value(), random_value(),
               random_value(), random_value());
  endtask

  task automatic queue_query(input logic signed [QPOS_W-1:0] p);
    command_t c;
    c       = '0;
    // Load fields are don't-care on a query.
    c.row   = ROW_W'($urandom);
    c.grid  = GRID_W'($urandom);
    c.rho   = $urandom;
    c.alpha = $urandom;
    c.tau   = $urandom;
    c.time0 = $urandom;
    c.ampli = $urandom;
    c.kind  = KIND_QUERY;
    c.pos   = p;
    command_q = {command_q, c};
  endtask

  // Random phase: reload the window with a clean unit grid, then mix queries
  // with window reloads and the occasional noise load anywhere in the table.
  task automatic queue_random_items(input int n);
    int                       made, pick, row, tries;
    longint                   mag;
    logic signed [QPOS_W-1:0] p;
    for (row = 0; row < WIN_ROWS; row++) queue_random_load(row, GRID_W'(row * 256));
    for (made = WIN_ROWS; made < n; made++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        row = $urandom_range(WIN_ROWS - 1);
        queue_random_load(row, ($urandom_range(7) == 0) ? GRID_W'($urandom)
                                                        : GRID_W'(row * 256));
      end else if (pick < 25) begin
        queue_random_load(int'($urandom_range(TR - 1)), GRID_W'($urandom));
      end else begin
        if (pick < 85) begin
          p = window_pos();
        end else if (pick < 92) begin
          // Right at the upper limit, one step either side of it.
          mag = longint'(planned_grid[cfg_last_row]) + longint'($urandom_range(2)) - 1;
          if (mag < 0) mag = 0;
          p = ($urandom_range(1) || mag > 8388607) ? QPOS_W'(-mag) : QPOS_W'(mag);
        end else begin
          p = QPOS_W'($urandom);
          for (tries = 0; tries < 8 && !rows_ready(p); tries++) p = QPOS_W'($urandom);
        end
        if (!rows_ready(p)) p = window_pos();
        queue_query(p);
      end
    end
  endtask

  // Waits until every queued transaction is taken and every result is back,
  // then lets the pipeline empty out before the registers are touched.
  task automatic wait_drained();
    while (command_q.size() != 0 || holding || expected_shapes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_LAST_ROW) cfg_last_row = data[ROW_W-1:0];
    else cfg_bin_scale = data[SCALE_W-1:0];
  endtask

  task automatic run_phase(input int idle_pct, input logic [CFG_W-1:0] last_row_val,
                           input logic [CFG_W-1:0] scale_val, input int n);
    wait_drained();
    sender_idle_pct = idle_pct;
    write_reg(REG_LAST_ROW, last_row_val);
    write_reg(REG_BIN_SCALE, scale_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_random_items(n);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. The directed part runs on the reset register values (last row
  // 1, bin scale 25.0). The random phases then step through register
  // settings, extremes included, and through the sender idling rates.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Rows 0 and 1 start out far from the unit grid, and row 1 sits at the
    // top of the grid, so every position below it interpolates. Opposite
    // full-scale values make the weight clamp and the output clamps bite.
    queue_load(0, 22'h3FFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h0000_0000, 32'hFFFF_FFFF);
    queue_load(1, 22'h3FFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000);
    queue_random_load(2, 22'd512);
    queue_random_load(32, 22'd0);
    queue_random_load(33, 22'd0);
    queue_load(16383, 22'h3FFFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
               32'hAAAA_AAAA, 32'h0000_0000);
    queue_load(16382, 22'h2AAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
               32'h5555_5555, 32'hFFFF_FFFF);
    queue_random_load(14'h1555, 22'h155555);

    queue_query(24'sd0);                // weight clamps at the negative limit
    queue_query(24'sd8292);             // weight clamps at the positive limit
    queue_query(-24'sd8292);
    queue_query(24'sh7FFFFF);           // largest positive position, beyond
    queue_query(24'sh800000);           // most negative position, beyond
    queue_query(24'sh3FFFFF);           // exactly on the upper limit
    queue_query(24'sh3FFFFE);           // just below it, both rows saturate

    // Back to a proper unit grid at the bottom of the table.
    queue_load(0, 22'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h0000_0000, 32'hFFFF_FFFF);
    queue_load(1, 22'd256, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000);
    queue_query(24'sd128);
    queue_query(-24'sd1);
    queue_query(24'sd255);
    queue_query(24'sd256);              // exactly on the limit of row 1
    queue_query(-24'sd257);

    run_phase(37, 16'd48, 16'd256, 288);
    run_phase(37, 16'd0, 16'hFFFF, 288);          // last row 0, largest scale
    run_phase(61, 16'hFFFF, 16'd0, 288);          // top row via unused data bits
    run_phase(61, 16'd30, CFG_W'($urandom), 288);
    run_phase(0, 16'd48, 16'd6400, 288);
    run_phase(0, CFG_W'($urandom_range(WIN_ROWS - 1)), CFG_W'($urandom), 288);

    wait_drained();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver. A transaction completes at an edge where start is high and busy
  // is low; the table model is updated right there, in acceptance order.
  // The next command is then presented, unless the sender idles this cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (holding && start && !busy) begin
        apply_command(current_cmd);
        holding = 1'b0;
      end
      if (!holding && command_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        current_cmd = command_q.pop_front();
        holding = 1'b1;
      end
      start      <= holding;
      kind       <= current_cmd.kind;
      row_index  <= current_cmd.row;
      grid_x     <= current_cmd.grid;
      load_rho   <= current_cmd.rho;
      load_alpha <= current_cmd.alpha;
      load_tau   <= current_cmd.tau;
      load_time0 <= current_cmd.time0;
      load_ampli <= current_cmd.ampli;
      query_pos  <= current_cmd.pos;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. A result is valid for the single cycle that done marks and is
  // matched against the oldest expected shape. An unknown done counts as a
  // result, so it cannot slip past unnoticed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    shape_t got, want;
    if (!rst && done !== 1'b0) begin
      got.rho      = rho_out;
      got.alpha    = alpha_out;
      got.tau      = tau_out;
      got.tau_bins = tau_bins_out;
      got.time0    = time0_out;
      got.ampli    = ampli_out;
      got.beyond   = beyond_table;
      if (expected_shapes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with none expected", $realtime);
          $display("  actual   rho=%h alpha=%h tau=%h bins=%h t0=%h amp=%h beyond=%b",
                   got.rho, got.alpha, got.tau, got.tau_bins, got.time0,
                   got.ampli, got.beyond);
        end
      end else begin
        want = expected_shapes.pop_front();
        if (got.rho !== want.rho || got.alpha !== want.alpha || got.tau !== want.tau ||
            got.tau_bins !== want.tau_bins || got.time0 !== want.time0 ||
            got.ampli !== want.ampli || got.beyond !== want.beyond) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: shape mismatch", $realtime);
            $display("  expected rho=%h alpha=%h tau=%h bins=%h t0=%h amp=%h beyond=%b",
                     want.rho, want.alpha, want.tau, want.tau_bins, want.time0,
                     want.ampli, want.beyond);
            $display("  actual   rho=%h alpha=%h tau=%h bins=%h t0=%h amp=%h beyond=%b",
                     got.rho, got.alpha, got.tau, got.tau_bins, got.time0,
                     got.ampli, got.beyond);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if neither a command nor a result moves within
  // the quiet limit.
  always @(posedge clk) begin : watchdog
    if ((start && !busy) || done === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
